[rtl/core/mpfb_pkg.sv]
// Package: shared types, codes and defaults of the page-mode frame buffer.
`default_nettype none

package mpfb_pkg;

	// Default geometry of the store.
	localparam int DEF_COLUMNS = 64;
	localparam int DEF_PAGES   = 16;

	// Input command codes.
	localparam logic [1:0] CMD_PIXEL = 2'd0;
	localparam logic [1:0] CMD_FLUSH = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_LANDSCAPE = 2'd0;
	localparam logic [1:0] REG_UPPER_COL = 2'd1;
	localparam logic [1:0] REG_LOWER_COL = 2'd2;
	localparam logic [1:0] REG_PAGE      = 2'd3;

	// Register reset values.
	localparam logic [7:0] RST_UPPER_COL = 8'h10;
	localparam logic [7:0] RST_LOWER_COL = 8'h00;
	localparam logic [7:0] RST_PAGE      = 8'hB0;

	// Number of command bytes that open every page.
	localparam logic [8:0] HDR_BYTES = 9'd3;

	typedef struct packed {
		logic       landscape;
		logic [7:0] upper_col_opcode;
		logic [7:0] lower_col_opcode;
		logic [7:0] page_opcode;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic take_pixel;
		logic take_flush;
		logic take_tick;
		logic pix_write;
		logic emit;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done;
		logic flush_busy;
		logic out_free;
	} ctl_sts_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PIX_WR,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

[rtl/core/mpfb_regs.sv]
// Configuration registers behind the APB-style port.
`default_nettype none

module mpfb_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output mpfb_pkg::cfg_t         cfg
);
	import mpfb_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.landscape        <= 1'b0;
			cfg_q.upper_col_opcode <= RST_UPPER_COL;
			cfg_q.lower_col_opcode <= RST_LOWER_COL;
			cfg_q.page_opcode      <= RST_PAGE;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_LANDSCAPE: cfg_q.landscape        <= pwdata[0];
				REG_UPPER_COL: cfg_q.upper_col_opcode <= pwdata[7:0];
				REG_LOWER_COL: cfg_q.lower_col_opcode <= pwdata[7:0];
				REG_PAGE:      cfg_q.page_opcode      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		case (paddr[3:2])
			REG_LANDSCAPE: prdata = {31'd0, cfg_q.landscape};
			REG_UPPER_COL: prdata = {24'd0, cfg_q.upper_col_opcode};
			REG_LOWER_COL: prdata = {24'd0, cfg_q.lower_col_opcode};
			REG_PAGE:      prdata = {24'd0, cfg_q.page_opcode};
			default:       prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/mpfb_ctrl.sv]
// Controller state machine: accepts items and sequences the datapath.
`default_nettype none

module mpfb_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [1:0]         command,
	output logic                    in_stall,
	input  wire mpfb_pkg::ctl_sts_t sts,
	output mpfb_pkg::ctl_cmd_t      cmd
);
	import mpfb_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (command)
						CMD_PIXEL: begin
							cmd.take_pixel = 1'b1;
							state_d        = ST_PIX_WR;
						end
						CMD_FLUSH: begin
							cmd.take_flush = 1'b1;
						end
						CMD_TICK: begin
							if (sts.flush_busy) begin
								cmd.take_tick = 1'b1;
								state_d       = ST_EMIT;
							end
						end
						default: ;
					endcase
				end
			end
			ST_PIX_WR: begin
				cmd.pix_write = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	// A tick that produces a byte always moves the controller to the emit state next.
	a_tick_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_tick |=> state_q == ST_EMIT)
		else $error("tick did not move to emit");

	// Every pixel read is followed by its write back.
	a_pix_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_pixel |=> cmd.pix_write)
		else $error("pixel read without write back");

	// Nothing is accepted until the clearing pass has finished.
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear && !sts.clear_done |=> in_stall)
		else $error("item accepted during clearing pass");
`endif

endmodule

`default_nettype wire

[rtl/core/mpfb_dp.sv]
// Datapath: frame store, flush sequencer registers and output register.
`default_nettype none

module mpfb_dp #(
	parameter int COLUMNS = mpfb_pkg::DEF_COLUMNS,
	parameter int PAGES   = mpfb_pkg::DEF_PAGES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mpfb_pkg::cfg_t     cfg,
	input  wire mpfb_pkg::ctl_cmd_t cmd,
	output mpfb_pkg::ctl_sts_t      sts,
	input  wire logic [6:0]         pixel_x,
	input  wire logic [6:0]         pixel_y,
	input  wire logic               pixel_on,
	input  wire logic [6:0]         area_x1,
	input  wire logic [6:0]         area_y1,
	input  wire logic [6:0]         area_x2,
	input  wire logic [6:0]         area_y2,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              out_byte,
	output logic                    is_command,
	output logic                    last_byte
);
	import mpfb_pkg::*;

	localparam int STORE = COLUMNS * PAGES;
	localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
	// Wide enough for any store index the sequencer or a pixel can form.
	localparam int IDX_W = $clog2(COLUMNS * 16 + 260);

	// Frame store.
	logic [7:0]       mem [STORE];
	logic [7:0]       rdata_q;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [7:0]       wr_data;

	// Clearing pass.
	logic [AW-1:0]    clr_q;

	// Pixel read-modify-write.
	logic [6:0]       pix_col;
	logic [6:0]       pix_row;
	logic [IDX_W-1:0] pix_idx;
	logic             pix_ok;
	logic [AW-1:0]    pix_addr_q;
	logic [7:0]       pix_mask_q;
	logic             pix_on_q;
	logic             pix_ok_q;

	// Flush sequencer.
	logic             busy_q;
	logic [3:0]       cur_page_q;
	logic [3:0]       last_page_q;
	logic [6:0]       first_col_q;
	logic [7:0]       col_count_q;
	logic [8:0]       byte_pos_q;
	logic [IDX_W-1:0] row_off_q;

	logic [6:0]       fl_c0;
	logic [6:0]       fl_c1;
	logic [3:0]       fl_p0;
	logic [3:0]       fl_p1;

	logic             tk_is_cmd;
	logic [7:0]       tk_cmd_byte;
	logic [IDX_W-1:0] tk_idx;
	logic             tk_oob;
	logic [8:0]       tk_next;
	logic             tk_page_end;
	logic             tk_last;

	// Pending byte between tick and output register.
	logic             em_cmd_q;
	logic [7:0]       em_byte_q;
	logic             em_zero_q;
	logic             em_last_q;

	// Output register.
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             is_command_q;
	logic             last_byte_q;

	// Pixel address: column plus one row of COLUMNS bytes per page.
	always_comb begin
		pix_col = cfg.landscape ? pixel_y : pixel_x;
		pix_row = cfg.landscape ? pixel_x : pixel_y;
		pix_idx = IDX_W'(pix_col) + IDX_W'(pix_row[6:3]) * IDX_W'(COLUMNS);
		pix_ok  = pix_idx < IDX_W'(STORE);
	end

	// Current tick byte and the sequencer advance.
	always_comb begin
		tk_is_cmd = byte_pos_q < HDR_BYTES;
		case (byte_pos_q[1:0])
			2'd0:    tk_cmd_byte = cfg.upper_col_opcode | {5'd0, first_col_q[6:4]};
			2'd1:    tk_cmd_byte = cfg.lower_col_opcode | {4'd0, first_col_q[3:0]};
			default: tk_cmd_byte = cfg.page_opcode | {4'd0, cur_page_q};
		endcase
		tk_idx      = row_off_q + IDX_W'(byte_pos_q) - IDX_W'(HDR_BYTES);
		tk_oob      = tk_idx >= IDX_W'(STORE);
		tk_next     = byte_pos_q + 9'd1;
		tk_page_end = tk_next >= (HDR_BYTES + {1'b0, col_count_q});
		tk_last     = tk_page_end && (cur_page_q == last_page_q);
	end

	// Flush area mapped to columns and pages.
	always_comb begin
		fl_c0 = cfg.landscape ? area_y1 : area_x1;
		fl_c1 = cfg.landscape ? area_y2 : area_x2;
		fl_p0 = cfg.landscape ? area_x1[6:3] : area_y1[6:3];
		fl_p1 = cfg.landscape ? area_x2[6:3] : area_y2[6:3];
	end

	// Memory port selection.
	always_comb begin
		rd_en   = cmd.take_pixel || (cmd.take_tick && !tk_is_cmd);
		rd_addr = cmd.take_pixel ? pix_idx[AW-1:0] : tk_idx[AW-1:0];
		wr_en   = cmd.clear || (cmd.pix_write && pix_ok_q);
		wr_addr = cmd.clear ? clr_q : pix_addr_q;
		wr_data = cmd.clear ? 8'd0 :
			(pix_on_q ? (rdata_q | pix_mask_q) : (rdata_q & ~pix_mask_q));
	end

	// Store write port.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	// Store read port with registered data.
	always_ff @(posedge clk) begin
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	// Clearing pass address counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// Captured pixel write.
	always_ff @(posedge clk) begin
		if (cmd.take_pixel) begin
			pix_addr_q <= pix_idx[AW-1:0];
			pix_mask_q <= 8'd1 << pix_row[2:0];
			pix_on_q   <= pixel_on;
			pix_ok_q   <= pix_ok;
		end
	end

	// Sequencer: loaded by a flush start, advanced by each tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cur_page_q  <= '0;
			last_page_q <= '0;
			first_col_q <= '0;
			col_count_q <= '0;
			byte_pos_q  <= '0;
			row_off_q   <= '0;
		end else if (cmd.take_flush) begin
			if (!busy_q && fl_p0 <= fl_p1) begin
				busy_q      <= 1'b1;
				cur_page_q  <= fl_p0;
				last_page_q <= fl_p1;
				first_col_q <= fl_c0;
				col_count_q <= 8'({1'b0, fl_c1} - {1'b0, fl_c0} + 8'd1);
				byte_pos_q  <= '0;
				row_off_q   <= '0;
			end
		end else if (cmd.take_tick) begin
			if (!tk_page_end) begin
				byte_pos_q <= tk_next;
			end else if (tk_last) begin
				busy_q     <= 1'b0;
				byte_pos_q <= '0;
			end else begin
				cur_page_q <= cur_page_q + 4'd1;
				row_off_q  <= row_off_q + IDX_W'(COLUMNS);
				byte_pos_q <= '0;
			end
		end
	end

	// Byte waiting for the output register.
	always_ff @(posedge clk) begin
		if (cmd.take_tick) begin
			em_cmd_q  <= tk_is_cmd;
			em_byte_q <= tk_cmd_byte;
			em_zero_q <= tk_oob;
			em_last_q <= tk_last;
		end
	end

	// Output register: holds a beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q   <= em_cmd_q ? em_byte_q : (em_zero_q ? 8'd0 : rdata_q);
			is_command_q <= em_cmd_q;
			last_byte_q  <= em_last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign is_command = is_command_q;
	assign last_byte  = last_byte_q;

	assign sts.clear_done = clr_q == AW'(STORE - 1);
	assign sts.flush_busy = busy_q;
	assign sts.out_free   = !out_valid_q || !out_stall;

`ifndef SYNTHESIS
	// The byte position never passes the end of a page.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> byte_pos_q < (HDR_BYTES + {1'b0, col_count_q}))
		else $error("byte position past end of page");

	// Pages run upward to the last page only.
	a_page_order: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cur_page_q <= last_page_q)
		else $error("current page beyond last page");

	// An idle sequencer always restarts at the first command byte.
	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> byte_pos_q == 9'd0)
		else $error("idle sequencer left with a byte position");

	// A tick is only issued while a flush is pending.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_tick |-> busy_q)
		else $error("tick issued with no flush pending");
`endif

endmodule

`default_nettype wire

[rtl/core/mono_page_framebuffer_flush.sv]
// Top level: page-mode monochrome frame buffer with flush sequencer.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_stall    | command, pixel_x/y, pixel_on, area_*
//  out     | output    | out_valid / out_stall  | out_byte, is_command, last_byte
//  cfg     | input     | psel/penable/pready    | paddr, pwdata, prdata
//
// A flush start, an idle tick and an unused command are taken without leaving idle. A
// pixel write reads the store, then writes back in ST_PIX_WR (separate read and write
// ports). A tick during a flush moves to ST_EMIT, which loads the output register when
// it is free and waits while a beat is held there under out_stall. After reset the
// store is cleared one byte a cycle with in_stall high; config writes still work.
`default_nettype none

module mono_page_framebuffer_flush #(
	parameter int COLUMNS = mpfb_pkg::DEF_COLUMNS,
	parameter int PAGES   = mpfb_pkg::DEF_PAGES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [6:0]  pixel_x,
	input  wire logic [6:0]  pixel_y,
	input  wire logic        pixel_on,
	input  wire logic [6:0]  area_x1,
	input  wire logic [6:0]  area_y1,
	input  wire logic [6:0]  area_x2,
	input  wire logic [6:0]  area_y2,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             is_command,
	output logic             last_byte
);
	import mpfb_pkg::*;

	cfg_t     cfg;
	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// Configuration registers.
	mpfb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Controller.
	mpfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath.
	mpfb_dp #(
		.COLUMNS (COLUMNS),
		.PAGES   (PAGES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.sts        (sts),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_on   (pixel_on),
		.area_x1    (area_x1),
		.area_y1    (area_y1),
		.area_x2    (area_x2),
		.area_y2    (area_y2),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.is_command (is_command),
		.last_byte  (last_byte)
	);

endmodule

`default_nettype wire
